### hw/rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)

`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

### hw/rtl/cbs_pkg.sv
package cbs_pkg;

  localparam int COORD_BITS_DEF  = 24;
  localparam int T_FRAC_BITS_DEF = 16;
  localparam int ATTR_BITS       = 16;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int PIPE_DEPTH      = 6;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SPLIT_POSITION = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KEEP_ENDS      = 2'd1;

endpackage

### hw/rtl/cbs_lerp.sv
module cbs_lerp #(
  parameter int W  = 24,
  parameter int TF = 16
) (
  input  logic                clk,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  input  logic        [TF:0]  t,
  output logic signed [W-1:0] y
);

  localparam int PW = W + TF + 3;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (TF - 1);

  logic signed [W:0]    diff;
  logic signed [TF+1:0] t_s;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] sum;
  logic signed [W-1:0]  a_q;
  logic signed [W-1:0]  y_next;

  // y = a + round((b - a) * t), result always lies between a and b
  always_comb begin
    diff   = {b[W-1], b} - {a[W-1], a};
    t_s    = {1'b0, t};
    sum    = prod + HALF;
    y_next = a_q + sum[TF+W-1:TF];
  end

  always_ff @(posedge clk) begin
    prod <= PW'(diff * t_s);
    a_q  <= a;
    y    <= y_next;
  end

endmodule

### hw/rtl/cubic_bezier_split_top.sv
// cubic bezier split at a configured t, de casteljau in three lerp levels
// throughput: one segment per cycle, busy stays low, done is never stalled
// each lerp level is a multiply stage and a round/add stage
// reset (rst, synchronous): t = one half, keep_ends = 0, pipeline emptied
`include "assert_macros.svh"

module cubic_bezier_split_top #(
  parameter int COORD_BITS  = cbs_pkg::COORD_BITS_DEF,
  parameter int T_FRAC_BITS = cbs_pkg::T_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cbs_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [T_FRAC_BITS:0]                  cfg_data,
  input  logic signed [COORD_BITS-1:0]          start_x,
  input  logic signed [COORD_BITS-1:0]          start_y,
  input  logic signed [COORD_BITS-1:0]          start_ctl_x,
  input  logic signed [COORD_BITS-1:0]          start_ctl_y,
  input  logic signed [COORD_BITS-1:0]          end_ctl_x,
  input  logic signed [COORD_BITS-1:0]          end_ctl_y,
  input  logic signed [COORD_BITS-1:0]          end_x,
  input  logic signed [COORD_BITS-1:0]          end_y,
  input  logic [cbs_pkg::ATTR_BITS-1:0]         start_opacity,
  input  logic [cbs_pkg::ATTR_BITS-1:0]         start_width,
  input  logic [cbs_pkg::ATTR_BITS-1:0]         end_opacity,
  input  logic [cbs_pkg::ATTR_BITS-1:0]         end_width,
  output logic                                  done,
  output logic signed [COORD_BITS-1:0]          mid_in_ctl_x,
  output logic signed [COORD_BITS-1:0]          mid_in_ctl_y,
  output logic signed [COORD_BITS-1:0]          mid_x,
  output logic signed [COORD_BITS-1:0]          mid_y,
  output logic signed [COORD_BITS-1:0]          mid_out_ctl_x,
  output logic signed [COORD_BITS-1:0]          mid_out_ctl_y,
  output logic signed [COORD_BITS-1:0]          new_start_ctl_x,
  output logic signed [COORD_BITS-1:0]          new_start_ctl_y,
  output logic signed [COORD_BITS-1:0]          new_end_ctl_x,
  output logic signed [COORD_BITS-1:0]          new_end_ctl_y,
  output logic [cbs_pkg::ATTR_BITS-1:0]         mid_opacity,
  output logic [cbs_pkg::ATTR_BITS-1:0]         mid_width
);

  import cbs_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int AB = ATTR_BITS + 1;
  localparam logic [T_FRAC_BITS:0] T_ONE  = (T_FRAC_BITS+1)'(1) << T_FRAC_BITS;
  localparam logic [T_FRAC_BITS:0] T_HALF = (T_FRAC_BITS+1)'(1) << (T_FRAC_BITS - 1);

  logic [T_FRAC_BITS:0] split_position;
  logic                 keep_ends;
  logic [PIPE_DEPTH-1:0] vld;

  logic signed [CB-1:0] p01_x, p01_y, p12_x, p12_y, p23_x, p23_y;
  logic signed [CB-1:0] p012_x, p012_y, p123_x, p123_y;
  logic signed [AB-1:0] op_l1, wd_l1;

  logic signed [CB-1:0] p1x_d1, p1y_d1, p2x_d1, p2y_d1;
  logic signed [CB-1:0] p1x_d2, p1y_d2, p2x_d2, p2y_d2;
  logic signed [CB-1:0] nsx_d [4];
  logic signed [CB-1:0] nsy_d [4];
  logic signed [CB-1:0] nex_d [4];
  logic signed [CB-1:0] ney_d [4];
  logic signed [CB-1:0] icx_d, icy_d, ocx_d, ocy_d;
  logic [ATTR_BITS-1:0] op_d [4];
  logic [ATTR_BITS-1:0] wd_d [4];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign done      = vld[PIPE_DEPTH-1];

  // t is clamped to one as it is written
  always_ff @(posedge clk) begin
    if (rst) begin
      split_position <= T_HALF;
      keep_ends      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SPLIT_POSITION: split_position <= (cfg_data > T_ONE) ? T_ONE : cfg_data;
        REG_KEEP_ENDS:      keep_ends      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_DEPTH-2:0], start && !busy};
    end
  end

  // level one
  cbs_lerp #(.W(CB), .TF(T_FRAC_BITS)) u_p01_x (.clk(clk), .a(start_x),
    .b(start_ctl_x), .t(split_position), .y(p01_x));
  cbs_lerp #(.W(CB), .TF(T_FRAC_BITS)) u_p01_y (.clk(clk), .a(start_y),
    .b(start_ctl_y), .t(split_position), .y(p01_y));
  cbs_lerp #(.W(CB), .TF(T_FRAC_BITS)) u_p12_x (.clk(clk), .a(start_ctl_x),
    .b(end_ctl_x), .t(split_position), .y(p12_x));
  cbs_lerp #(.W(CB), .TF(T_FRAC_BITS)) u_p12_y (.clk(clk), .a(start_ctl_y),
    .b(end_ctl_y), .t(split_position), .y(p12_y));
  cbs_lerp #(.W(CB), .TF(T_FRAC_BITS)) u_p23_x (.clk(clk), .a(end_ctl_x),
    .b(end_x), .t(split_position), .y(p23_x));
  cbs_lerp #(.W(CB), .TF(T_FRAC_BITS)) u_p23_y (.clk(clk), .a(end_ctl_y),
    .b(end_y), .t(split_position), .y(p23_y));
  cbs_lerp #(.W(AB), .TF(T_FRAC_BITS)) u_op (.clk(clk), .a({1'b0, start_opacity}),
    .b({1'b0, end_opacity}), .t(split_position), .y(op_l1));
  cbs_lerp #(.W(AB), .TF(T_FRAC_BITS)) u_wd (.clk(clk), .a({1'b0, start_width}),
    .b({1'b0, end_width}), .t(split_position), .y(wd_l1));

  // level two
  cbs_lerp #(.W(CB), .TF(T_FRAC_BITS)) u_p012_x (.clk(clk), .a(p01_x),
    .b(p12_x), .t(split_position), .y(p012_x));
  cbs_lerp #(.W(CB), .TF(T_FRAC_BITS)) u_p012_y (.clk(clk), .a(p01_y),
    .b(p12_y), .t(split_position), .y(p012_y));
  cbs_lerp #(.W(CB), .TF(T_FRAC_BITS)) u_p123_x (.clk(clk), .a(p12_x),
    .b(p23_x), .t(split_position), .y(p123_x));
  cbs_lerp #(.W(CB), .TF(T_FRAC_BITS)) u_p123_y (.clk(clk), .a(p12_y),
    .b(p23_y), .t(split_position), .y(p123_y));

  // level three, straight onto the result ports
  cbs_lerp #(.W(CB), .TF(T_FRAC_BITS)) u_m_x (.clk(clk), .a(p012_x),
    .b(p123_x), .t(split_position), .y(mid_x));
  cbs_lerp #(.W(CB), .TF(T_FRAC_BITS)) u_m_y (.clk(clk), .a(p012_y),
    .b(p123_y), .t(split_position), .y(mid_y));

  // side delay lines, aligned with the lerp levels
  always_ff @(posedge clk) begin
    p1x_d1 <= start_ctl_x;
    p1y_d1 <= start_ctl_y;
    p2x_d1 <= end_ctl_x;
    p2y_d1 <= end_ctl_y;
    p1x_d2 <= p1x_d1;
    p1y_d2 <= p1y_d1;
    p2x_d2 <= p2x_d1;
    p2y_d2 <= p2y_d1;

    nsx_d[0] <= keep_ends ? p1x_d2 : p01_x;
    nsy_d[0] <= keep_ends ? p1y_d2 : p01_y;
    nex_d[0] <= keep_ends ? p2x_d2 : p23_x;
    ney_d[0] <= keep_ends ? p2y_d2 : p23_y;
    op_d[0]  <= op_l1[ATTR_BITS-1:0];
    wd_d[0]  <= wd_l1[ATTR_BITS-1:0];
    for (int i = 1; i < 4; i++) begin
      nsx_d[i] <= nsx_d[i-1];
      nsy_d[i] <= nsy_d[i-1];
      nex_d[i] <= nex_d[i-1];
      ney_d[i] <= ney_d[i-1];
      op_d[i]  <= op_d[i-1];
      wd_d[i]  <= wd_d[i-1];
    end

    icx_d         <= p012_x;
    icy_d         <= p012_y;
    ocx_d         <= p123_x;
    ocy_d         <= p123_y;
    mid_in_ctl_x  <= icx_d;
    mid_in_ctl_y  <= icy_d;
    mid_out_ctl_x <= ocx_d;
    mid_out_ctl_y <= ocy_d;
  end

  assign new_start_ctl_x = nsx_d[3];
  assign new_start_ctl_y = nsy_d[3];
  assign new_end_ctl_x   = nex_d[3];
  assign new_end_ctl_y   = ney_d[3];
  assign mid_opacity     = op_d[3];
  assign mid_width       = wd_d[3];

  `ASSERT_IMPLIES(a_latency, clk, rst, start && !busy, ##6 done)
  `ASSERT_NEVER(a_no_phantom, clk, rst, done && !$past(start && !busy, 6))
  `ASSERT_IMPLIES(a_keep_start, clk, rst, done && $past(keep_ends, 4),
    new_start_ctl_x == $past(start_ctl_x, 6) && new_end_ctl_y == $past(end_ctl_y, 6))

endmodule

### dv/split_checker.sv
`timescale 1ns / 1ps

module split_checker #(
  parameter int CW = cbs_pkg::COORD_BITS_DEF,
  parameter int TF = cbs_pkg::T_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [cbs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [TF:0]                       cfg_data,
  input  logic signed [CW-1:0]              start_x,
  input  logic signed [CW-1:0]              start_y,
  input  logic signed [CW-1:0]              start_ctl_x,
  input  logic signed [CW-1:0]              start_ctl_y,
  input  logic signed [CW-1:0]              end_ctl_x,
  input  logic signed [CW-1:0]              end_ctl_y,
  input  logic signed [CW-1:0]              end_x,
  input  logic signed [CW-1:0]              end_y,
  input  logic [cbs_pkg::ATTR_BITS-1:0]     start_opacity,
  input  logic [cbs_pkg::ATTR_BITS-1:0]     start_width,
  input  logic [cbs_pkg::ATTR_BITS-1:0]     end_opacity,
  input  logic [cbs_pkg::ATTR_BITS-1:0]     end_width,
  input  logic                              done,
  input  logic signed [CW-1:0]              mid_in_ctl_x,
  input  logic signed [CW-1:0]              mid_in_ctl_y,
  input  logic signed [CW-1:0]              mid_x,
  input  logic signed [CW-1:0]              mid_y,
  input  logic signed [CW-1:0]              mid_out_ctl_x,
  input  logic signed [CW-1:0]              mid_out_ctl_y,
  input  logic signed [CW-1:0]              new_start_ctl_x,
  input  logic signed [CW-1:0]              new_start_ctl_y,
  input  logic signed [CW-1:0]              new_end_ctl_x,
  input  logic signed [CW-1:0]              new_end_ctl_y,
  input  logic [cbs_pkg::ATTR_BITS-1:0]     mid_opacity,
  input  logic [cbs_pkg::ATTR_BITS-1:0]     mid_width,
  output int                                mismatches,
  output int                                outstanding
);

  localparam int AW = cbs_pkg::ATTR_BITS;
  localparam longint T_ONE = longint'(1) << TF;
  localparam longint T_HALF = T_ONE >> 1;
  localparam longint C_MAX = (longint'(1) << (CW - 1)) - 1;
  localparam longint C_MIN = -C_MAX - 1;
  localparam longint A_MAX = (longint'(1) << AW) - 1;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [AW-1:0] attr_t;

  typedef struct {
    coord_t in_ctl_x;
    coord_t in_ctl_y;
    coord_t pt_x;
    coord_t pt_y;
    coord_t out_ctl_x;
    coord_t out_ctl_y;
    coord_t st_ctl_x;
    coord_t st_ctl_y;
    coord_t en_ctl_x;
    coord_t en_ctl_y;
    attr_t  opacity;
    attr_t  width;
  } split_t;

  typedef struct {
    longint c01;
    longint c23;
    longint c012;
    longint c123;
    longint on_curve;
  } axis_t;

  logic [TF:0] split_pos;
  logic        keep_ends;
  split_t      expected_splits[$];

  // round to nearest, ties towards plus infinity
  function automatic longint lerp_q(longint a, longint b, longint s, longint t);
    return (a * s + b * t + T_HALF) >>> TF;
  endfunction

  function automatic longint sat_coord(longint v);
    if (v > C_MAX) return C_MAX;
    if (v < C_MIN) return C_MIN;
    return v;
  endfunction

  function automatic axis_t split_axis(longint p0, longint p1, longint p2, longint p3,
                                       longint s, longint t);
    axis_t a;
    longint c12;
    a.c01 = sat_coord(lerp_q(p0, p1, s, t));
    c12 = sat_coord(lerp_q(p1, p2, s, t));
    a.c23 = sat_coord(lerp_q(p2, p3, s, t));
    a.c012 = sat_coord(lerp_q(a.c01, c12, s, t));
    a.c123 = sat_coord(lerp_q(c12, a.c23, s, t));
    a.on_curve = sat_coord(lerp_q(a.c012, a.c123, s, t));
    return a;
  endfunction

  function automatic attr_t lerp_attr(longint a, longint b, longint s, longint t);
    longint r;
    r = lerp_q(a, b, s, t);
    if (r < 0) r = 0;
    if (r > A_MAX) r = A_MAX;
    return attr_t'(r);
  endfunction

  function automatic split_t predict_split();
    split_t r;
    axis_t ax;
    axis_t ay;
    longint t;
    longint s;
    t = (longint'(split_pos) > T_ONE) ? T_ONE : longint'(split_pos);
    s = T_ONE - t;
    ax = split_axis(start_x, start_ctl_x, end_ctl_x, end_x, s, t);
    ay = split_axis(start_y, start_ctl_y, end_ctl_y, end_y, s, t);
    r.in_ctl_x = coord_t'(ax.c012);
    r.in_ctl_y = coord_t'(ay.c012);
    r.pt_x = coord_t'(ax.on_curve);
    r.pt_y = coord_t'(ay.on_curve);
    r.out_ctl_x = coord_t'(ax.c123);
    r.out_ctl_y = coord_t'(ay.c123);
    r.st_ctl_x = keep_ends ? start_ctl_x : coord_t'(ax.c01);
    r.st_ctl_y = keep_ends ? start_ctl_y : coord_t'(ay.c01);
    r.en_ctl_x = keep_ends ? end_ctl_x : coord_t'(ax.c23);
    r.en_ctl_y = keep_ends ? end_ctl_y : coord_t'(ay.c23);
    r.opacity = lerp_attr(start_opacity, end_opacity, s, t);
    r.width = lerp_attr(start_width, end_width, s, t);
    return r;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    split_t want;
    if (rst) begin
      split_pos = (TF + 1)'(T_HALF);
      keep_ends = 1'b0;
      expected_splits.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == cbs_pkg::REG_SPLIT_POSITION) split_pos = cfg_data;
        else if (cfg_index == cbs_pkg::REG_KEEP_ENDS) keep_ends = cfg_data[0];
      end
      if (start && !busy) expected_splits.insert(expected_splits.size(), predict_split());
      if (done) begin
        if (expected_splits.size() == 0) begin
          $error("result beat with no segment outstanding");
          mismatches++;
        end else begin
          want = expected_splits.pop_front();
          check_field("mid_in_ctl_x", want.in_ctl_x, mid_in_ctl_x);
          check_field("mid_in_ctl_y", want.in_ctl_y, mid_in_ctl_y);
          check_field("mid_x", want.pt_x, mid_x);
          check_field("mid_y", want.pt_y, mid_y);
          check_field("mid_out_ctl_x", want.out_ctl_x, mid_out_ctl_x);
          check_field("mid_out_ctl_y", want.out_ctl_y, mid_out_ctl_y);
          check_field("new_start_ctl_x", want.st_ctl_x, new_start_ctl_x);
          check_field("new_start_ctl_y", want.st_ctl_y, new_start_ctl_y);
          check_field("new_end_ctl_x", want.en_ctl_x, new_end_ctl_x);
          check_field("new_end_ctl_y", want.en_ctl_y, new_end_ctl_y);
          check_field("mid_opacity", want.opacity, mid_opacity);
          check_field("mid_width", want.width, mid_width);
        end
      end
    end
    outstanding = expected_splits.size();
  end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int CW = cbs_pkg::COORD_BITS_DEF;
  localparam int TF = cbs_pkg::T_FRAC_BITS_DEF;
  localparam int AW = cbs_pkg::ATTR_BITS;
  localparam int IW = cbs_pkg::CFG_INDEX_BITS;
  localparam int SETTLE = cbs_pkg::PIPE_DEPTH + 2;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 110;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [AW-1:0] attr_t;
  typedef logic [TF:0] tpos_t;

  localparam logic [IW-1:0] REG_SPARE_A = IW'(2);
  localparam logic [IW-1:0] REG_SPARE_B = IW'(3);
  localparam coord_t C_MAX = {1'b0, {(CW - 1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(CW - 1){1'b0}}};
  localparam attr_t A_MAX = '1;
  localparam int T_ONE = 1 << TF;
  localparam int T_TOP = (1 << (TF + 1)) - 1;

  logic         clk;
  logic         rst;
  logic         start;
  logic         busy;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [IW-1:0] cfg_index;
  logic [TF:0]  cfg_data;
  coord_t       start_x, start_y, start_ctl_x, start_ctl_y;
  coord_t       end_ctl_x, end_ctl_y, end_x, end_y;
  attr_t        start_opacity, start_width, end_opacity, end_width;
  logic         done;
  coord_t       mid_in_ctl_x, mid_in_ctl_y, mid_x, mid_y, mid_out_ctl_x, mid_out_ctl_y;
  coord_t       new_start_ctl_x, new_start_ctl_y, new_end_ctl_x, new_end_ctl_y;
  attr_t        mid_opacity, mid_width;
  int           mismatches;
  int           outstanding;

  cubic_bezier_split_top i_dut (.*);

  split_checker i_check (.*);

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic load_segment(coord_t x0, coord_t y0, coord_t x1, coord_t y1,
                              coord_t x2, coord_t y2, coord_t x3, coord_t y3,
                              attr_t o0, attr_t w0, attr_t o1, attr_t w1);
    start_x <= x0;
    start_y <= y0;
    start_ctl_x <= x1;
    start_ctl_y <= y1;
    end_ctl_x <= x2;
    end_ctl_y <= y2;
    end_x <= x3;
    end_y <= y3;
    start_opacity <= o0;
    start_width <= w0;
    end_opacity <= o1;
    end_width <= w1;
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: return C_MAX;
      1: return C_MIN;
      2: return coord_t'(int'($urandom_range(0, 2)) - 1);
      3, 4: return coord_t'(int'($urandom_range(0, 4095)) - 2048);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic attr_t rand_attr();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return A_MAX;
      default: return attr_t'($urandom);
    endcase
  endfunction

  // one beat on the segment channel, called at a falling edge
  task automatic send_segment(int gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [IW-1:0] idx, tpos_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    int gap_max;
    rst = 1'b1;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    load_segment('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0);
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // corners at the reset split, t one half
    load_segment('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0);
    send_segment(0);
    load_segment(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                 A_MAX, A_MAX, A_MAX, A_MAX);
    send_segment(0);
    load_segment(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                 '0, A_MAX, '0, A_MAX);
    send_segment(1);
    load_segment(C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN,
                 '0, A_MAX, A_MAX, '0);
    send_segment(0);
    load_segment(C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX,
                 A_MAX, '0, '0, A_MAX);
    send_segment(2);
    // rounding ties on both sides of zero
    load_segment(coord_t'(0), coord_t'(-1), coord_t'(1), coord_t'(0),
                 coord_t'(0), coord_t'(-1), coord_t'(1), coord_t'(0),
                 attr_t'(0), attr_t'(1), attr_t'(1), attr_t'(0));
    send_segment(0);
    load_segment(coord_t'(-3), coord_t'(3), coord_t'(-2), coord_t'(2),
                 coord_t'(-1), coord_t'(1), coord_t'(0), coord_t'(0),
                 attr_t'(3), attr_t'(2), attr_t'(0), attr_t'(1));
    send_segment(0);
    load_segment(C_MAX, coord_t'(0), C_MIN, coord_t'(-1), C_MAX, coord_t'(1),
                 C_MIN, coord_t'(0), attr_t'(1), A_MAX, attr_t'(0), attr_t'(A_MAX - 1));
    send_segment(3);

    for (int ph = 0; ph < PHASES; ph++) begin
      start <= 1'b0;
      wait_idle();
      case (ph)
        0: begin
          write_reg(cbs_pkg::REG_SPLIT_POSITION, '0);
          write_reg(cbs_pkg::REG_KEEP_ENDS, tpos_t'(1));
        end
        1: begin
          write_reg(cbs_pkg::REG_SPLIT_POSITION, tpos_t'(T_ONE));
          // upper data bits are dropped by keep_ends
          write_reg(cbs_pkg::REG_KEEP_ENDS, tpos_t'(T_TOP - 1));
        end
        2: begin
          write_reg(cbs_pkg::REG_SPLIT_POSITION, tpos_t'(T_TOP));
          write_reg(cbs_pkg::REG_KEEP_ENDS, tpos_t'(3));
        end
        3: begin
          write_reg(cbs_pkg::REG_SPLIT_POSITION, tpos_t'(T_ONE + 1));
          write_reg(REG_SPARE_A, tpos_t'($urandom));
          write_reg(cbs_pkg::REG_KEEP_ENDS, '0);
        end
        4: begin
          write_reg(cbs_pkg::REG_SPLIT_POSITION, tpos_t'(1));
          write_reg(REG_SPARE_B, tpos_t'($urandom));
        end
        5: begin
          write_reg(cbs_pkg::REG_SPLIT_POSITION, tpos_t'(T_ONE - 1));
          write_reg(cbs_pkg::REG_KEEP_ENDS, tpos_t'(1));
        end
        default: begin
          if ($urandom_range(0, 7) == 0)
            write_reg(cbs_pkg::REG_SPLIT_POSITION, tpos_t'($urandom_range(T_ONE + 1, T_TOP)));
          else
            write_reg(cbs_pkg::REG_SPLIT_POSITION, tpos_t'($urandom_range(0, T_ONE)));
          write_reg(cbs_pkg::REG_KEEP_ENDS, tpos_t'($urandom));
          if ($urandom_range(0, 1) == 1)
            write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_A : REG_SPARE_B,
                      tpos_t'($urandom));
        end
      endcase
      cfg_valid <= 1'b0;

      gap_max = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // stretches of back to back beats between gappy ones
        if (n % 22 == 0) gap_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
        load_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     rand_attr(), rand_attr(), rand_attr(), rand_attr());
        send_segment($urandom_range(0, gap_max));
      end
    end

    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (2 * cbs_pkg::PIPE_DEPTH) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
